// File: src/lpfr_pkg.sv
// shared types and constants for the length-prefixed frame receiver
// no dependencies; imported by the front, queue, back, top level and bench
package lpfr_pkg;

  // payload buffer geometry
  localparam int BUF_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // length prefix is four bytes, most significant first
  localparam int LEN_BYTES = 4;

  // decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_BYTE = 1'd1;
  localparam logic [7:0] SYNC_BYTE_RST = 8'h0a;  // newline
  localparam logic [7:0] ECHO_BYTE_RST = 8'h40;  // at sign

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_RX      = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // one result request as it travels from front to output
  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_value;
    logic        frame_done;
    logic [7:0]  read_data;
    logic        read_ok;
    logic        overflow;
    phase_t      phase;
    logic [31:0] frame_length;
    logic [10:0] byte_count;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } q_push_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

endpackage

// File: src/lpfr_if.sv
// valid/ready channel interfaces for requests and results
// depends on nothing; payload widths are fixed by the field list
interface lpfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic [9:0] read_index;

  modport source (output valid, cmd, rx_byte, read_index, input ready);
  modport sink   (input valid, cmd, rx_byte, read_index, output ready);
endinterface

interface lpfr_out_if;
  logic        valid;
  logic        ready;
  logic        echo_valid;
  logic [7:0]  echo_value;
  logic        frame_done;
  logic [7:0]  read_data;
  logic        read_ok;
  logic        overflow;
  logic [1:0]  phase;
  logic [31:0] frame_length;
  logic [10:0] byte_count;

  modport source (output valid, echo_valid, echo_value, frame_done, read_data, read_ok,
                  overflow, phase, frame_length, byte_count, input ready);
  modport sink   (input valid, echo_valid, echo_value, frame_done, read_data, read_ok,
                  overflow, phase, frame_length, byte_count, output ready);
endinterface

// File: src/lpfr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module lpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/lpfr_front.sv
// front end: accepts requests, runs the phase machine, drives the buffer ram
// depends on lpfr_pkg and lpfr_in_if; pushes finished results to the queue
module lpfr_front import lpfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lpfr_in_if.sink              in_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic [QCNT_W-1:0]    q_count,
  output ram_wr_t              ram_wr,
  output logic [ADDR_W-1:0]    ram_raddr,
  input  logic [7:0]           ram_rdata,
  output q_push_t              q_push
);

  logic [7:0]       sync_byte_r;
  logic [7:0]       echo_byte_r;
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      length_r, length_nxt;
  logic             ovf_r, ovf_nxt;
  logic             stage_valid_r;
  result_t          stage_res_r, res_nxt;

  logic             accept;
  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      len_shift;
  logic [31:0]      idx_ext;
  logic             echo, done, rok;

  // room for this request plus the one still waiting on ram data
  always_comb begin
    if (stage_valid_r) begin
      in_ch.ready = (q_count < QCNT_W'(QDEPTH - 1));
    end else begin
      in_ch.ready = (q_count < QCNT_W'(QDEPTH));
    end
  end

  assign accept    = in_ch.valid && in_ch.ready;
  assign cnt_inc   = count_r + 1'b1;
  assign len_shift = {length_r[23:0], in_ch.rx_byte};
  assign idx_ext   = 32'(in_ch.read_index);
  assign ram_raddr = ADDR_W'(in_ch.read_index);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= SYNC_BYTE_RST;
      echo_byte_r <= ECHO_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_BYTE: sync_byte_r <= cfg_wdata;
        CFG_ECHO_BYTE: echo_byte_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // phase machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC;
      count_r  <= '0;
      length_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      length_r <= length_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // next state, buffer write and per-request flags
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    length_nxt  = length_r;
    ovf_nxt     = ovf_r;
    echo        = 1'b0;
    done        = 1'b0;
    rok         = 1'b0;
    ram_wr.we   = 1'b0;
    ram_wr.addr = count_r[ADDR_W-1:0];
    ram_wr.data = in_ch.rx_byte;
    if (accept) begin
      case (cmd_t'(in_ch.cmd))
        CMD_RX: begin
          case (phase_r)
            PH_SYNC: begin
              if (in_ch.rx_byte == sync_byte_r) begin
                echo      = 1'b1;
                phase_nxt = PH_LEN;
                count_nxt = '0;
              end
            end
            PH_LEN: begin
              length_nxt = len_shift;
              count_nxt  = cnt_inc;
              if (count_r == CNT_W'(LEN_BYTES - 1)) begin
                count_nxt = '0;
                if (len_shift == 32'd0) begin
                  phase_nxt = PH_DONE;
                  done      = 1'b1;
                end else begin
                  phase_nxt = PH_PAY;
                end
              end
            end
            PH_PAY: begin
              if (count_r >= CNT_W'(BUF_DEPTH)) begin
                // buffer full: drop the byte
                ovf_nxt = 1'b1;
              end else begin
                ram_wr.we = 1'b1;
                count_nxt = cnt_inc;
                if (32'(cnt_inc) == length_r) begin
                  phase_nxt = PH_DONE;
                  done      = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        CMD_READ: begin
          rok = (phase_r == PH_DONE) && (idx_ext < length_r) &&
                (idx_ext < 32'(BUF_DEPTH));
        end
        CMD_RELEASE: begin
          phase_nxt  = PH_LEN;
          count_nxt  = '0;
          length_nxt = '0;
          ovf_nxt    = 1'b0;
        end
        default: begin
          phase_nxt  = PH_SYNC;
          count_nxt  = '0;
          length_nxt = '0;
          ovf_nxt    = 1'b0;
        end
      endcase
    end
  end

  // result fields as they stand after this request
  always_comb begin
    res_nxt.echo_valid   = echo;
    res_nxt.echo_value   = echo_byte_r;
    res_nxt.frame_done   = done;
    res_nxt.read_data    = 8'd0;
    res_nxt.read_ok      = rok;
    res_nxt.overflow     = ovf_nxt;
    res_nxt.phase        = phase_nxt;
    res_nxt.frame_length = length_nxt;
    res_nxt.byte_count   = 11'(count_nxt);
  end

  // register the result while the ram read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_res_r <= res_nxt;
    end
  end

  // merge read data and hand over to the queue
  always_comb begin
    q_push.valid = stage_valid_r;
    q_push.res   = stage_res_r;
    if (stage_res_r.read_ok) begin
      q_push.res.read_data = ram_rdata;
    end
  end

endmodule

// File: src/lpfr_queue.sv
// short result queue between front and back
// depends on lpfr_pkg; push side never overruns since the front checks the level
module lpfr_queue import lpfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_push_t           push,
  input  logic              pop,
  output result_t           head,
  output logic [QCNT_W-1:0] count
);

  result_t           slot_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wptr_r] <= push.res;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push.valid) begin
        wptr_r <= ptr_inc(wptr_r);
      end
      if (pop) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      case ({push.valid, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  assign head  = slot_r[rptr_r];
  assign count = count_r;

endmodule

// File: src/lpfr_back.sv
// back end: output register that drains the queue onto the result channel
// depends on lpfr_pkg and lpfr_out_if
module lpfr_back import lpfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  result_t           q_head,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_pop,
  lpfr_out_if.source        out_ch
);

  logic    out_valid_r;
  result_t out_res_r;

  // load a new result when the register is empty or being taken
  assign q_pop = (q_count != '0) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res_r <= q_head;
    end
  end

  // drive the channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.echo_valid   = out_res_r.echo_valid;
  assign out_ch.echo_value   = out_res_r.echo_value;
  assign out_ch.frame_done   = out_res_r.frame_done;
  assign out_ch.read_data    = out_res_r.read_data;
  assign out_ch.read_ok      = out_res_r.read_ok;
  assign out_ch.overflow     = out_res_r.overflow;
  assign out_ch.phase        = out_res_r.phase;
  assign out_ch.frame_length = out_res_r.frame_length;
  assign out_ch.byte_count   = out_res_r.byte_count;

endmodule

// File: src/length_prefixed_frame_receiver.sv
// Length-prefixed frame receiver. Each request (received byte, read, release or
// restart) yields exactly one result. The block takes one request per clock
// cycle while the queue has room; the phase update and the buffer write for a
// byte happen in the cycle of acceptance, and a read uses one registered port
// of the payload ram. A result passes the ram read stage, the queue and the
// output register before it is presented on the output. A four-entry queue
// lets the input keep flowing while results wait to be taken, and the input
// stalls as it fills. The payload buffer is not cleared at reset and needs
// no clearing pass; reads only succeed for bytes of the current complete
// frame. Configuration writes belong in idle periods.
module length_prefixed_frame_receiver import lpfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lpfr_in_if.sink              in_ch,
  lpfr_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  q_push_t           q_push;
  result_t           q_head;
  logic [QCNT_W-1:0] q_count;
  logic              q_pop;

  lpfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .q_push    (q_push)
  );

  lpfr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpfr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .count (q_count)
  );

  lpfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_count (q_count),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  // a completed frame or a served read reports the done phase
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.frame_done || out_ch.read_ok) |-> out_ch.phase == PH_DONE)
    else $error("frame_done or read_ok outside the done phase");

  // sync found always moves on to the length phase with an empty count
  a_echo_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.echo_valid |-> out_ch.phase == PH_LEN && out_ch.byte_count == 11'd0)
    else $error("echo without entering the length phase");

  // a pushed result with no room would be lost
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid && !q_pop |-> q_count < QCNT_W'(QDEPTH))
    else $error("push into a full queue");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// self-checking bench for length_prefixed_frame_receiver: a scoreboard class
// predicts one result per accepted request and checks the result stream
// depends on lpfr_pkg and the lpfr_in_if / lpfr_out_if interfaces
module tb import lpfr_pkg::*; ();

  // predicts the receiver state and holds the results still owed by the block
  class frame_scoreboard;
    logic [7:0]  sync_val;
    logic [7:0]  echo_val;
    phase_t      phase;
    logic [10:0] count;
    logic [31:0] length;
    logic        ovf;
    logic [7:0]  payload [BUF_DEPTH];
    result_t     owed_q[$];
    int          errors;
    int          checked;
    int          frames_done;
    int          overflow_events;
    int          reads_served;

    function new();
      sync_val = SYNC_BYTE_RST;
      echo_val = ECHO_BYTE_RST;
      rearm(PH_SYNC);
    endfunction

    function void rearm(phase_t next_phase);
      phase  = next_phase;
      count  = '0;
      length = '0;
      ovf    = 1'b0;
    endfunction

    // predict the result of one accepted request; returns 0 if it was ignored
    function bit note_request(cmd_t c, logic [7:0] b, logic [9:0] ix);
      result_t r;
      bit acted;
      r = '0;
      acted = 1'b1;
      case (c)
        CMD_RX: begin
          case (phase)
            PH_SYNC: begin
              if (b == sync_val) begin
                r.echo_valid = 1'b1;
                phase = PH_LEN;
                count = '0;
              end else begin
                acted = 1'b0;
              end
            end
            PH_LEN: begin
              length = {length[23:0], b};
              count  = count + 11'd1;
              if (count >= LEN_BYTES) begin
                count = '0;
                if (length == 32'd0) begin
                  phase = PH_DONE;
                  r.frame_done = 1'b1;
                end else begin
                  phase = PH_PAY;
                end
              end
            end
            PH_PAY: begin
              // full buffer drops the byte and flags it
              if (count >= BUF_DEPTH) begin
                if (!ovf) overflow_events++;
                ovf = 1'b1;
              end else begin
                payload[count[ADDR_W-1:0]] = b;
                count = count + 11'd1;
                if ({21'd0, count} == length) begin
                  phase = PH_DONE;
                  r.frame_done = 1'b1;
                end
              end
            end
            default: begin
              acted = 1'b0;
            end
          endcase
        end
        CMD_READ: begin
          if (phase == PH_DONE && {22'd0, ix} < length) begin
            r.read_ok   = 1'b1;
            r.read_data = payload[ix];
            reads_served++;
          end
        end
        CMD_RELEASE: begin
          rearm(PH_LEN);
        end
        default: begin
          rearm(PH_SYNC);
        end
      endcase
      if (r.frame_done) frames_done++;
      r.echo_value   = echo_val;
      r.overflow     = ovf;
      r.phase        = phase;
      r.frame_length = length;
      r.byte_count   = count;
      owed_q.push_back(r);
      return acted;
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted result against the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      cmp_field("echo_valid", want.echo_valid, got.echo_valid);
      cmp_field("echo_value", want.echo_value, got.echo_value);
      cmp_field("frame_done", want.frame_done, got.frame_done);
      cmp_field("read_data", want.read_data, got.read_data);
      cmp_field("read_ok", want.read_ok, got.read_ok);
      cmp_field("overflow", want.overflow, got.overflow);
      cmp_field("phase", want.phase, got.phase);
      cmp_field("frame_length", want.frame_length, got.frame_length);
      cmp_field("byte_count", want.byte_count, got.byte_count);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  lpfr_in_if  in_ch();
  lpfr_out_if out_ch();

  length_prefixed_frame_receiver u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  frame_scoreboard sb;
  bit              idle_on;
  bit              stall_on;
  int              stall_left;
  int              requests_sent;
  int              requests_effective;
  result_t         got_res;

  always #10 clk = ~clk;

  // result monitor and random back-pressure
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_res.echo_valid   = out_ch.echo_valid;
      got_res.echo_value   = out_ch.echo_value;
      got_res.frame_done   = out_ch.frame_done;
      got_res.read_data    = out_ch.read_data;
      got_res.read_ok      = out_ch.read_ok;
      got_res.overflow     = out_ch.overflow;
      got_res.phase        = phase_t'(out_ch.phase);
      got_res.frame_length = out_ch.frame_length;
      got_res.byte_count   = out_ch.byte_count;
      sb.check_result(got_res);
    end
    if (stall_on && stall_left == 0 && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [9:0] rnd10();
    return 10'($urandom_range(0, 1023));
  endfunction

  // drive one request and hold it until the block takes it
  task automatic send_req(cmd_t c, logic [7:0] b, logic [9:0] ix);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.rx_byte    <= b;
    in_ch.read_index <= ix;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    if (sb.note_request(c, b, ix)) requests_effective++;
  endtask

  task automatic send_length(logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_req(CMD_RX, len[8*i +: 8], rnd10());
  endtask

  // hold off the sender until every owed result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] sync_v, logic [7:0] echo_v);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_BYTE;
    cfg_wdata <= sync_v;
    @(posedge clk);
    cfg_index <= CFG_ECHO_BYTE;
    cfg_wdata <= echo_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.sync_val = sync_v;
    sb.echo_val = echo_v;
  endtask

  // one well-formed frame with random content, sometimes cut short
  task automatic run_frame();
    logic [31:0] len;
    logic [7:0]  b;
    int unsigned pick;
    int unsigned n_pay;
    if (sb.phase != PH_LEN) begin
      if (sb.phase != PH_SYNC || $urandom_range(0, 1) == 1)
        send_req(CMD_RESTART, rnd8(), rnd10());
      repeat ($urandom_range(0, 2)) begin
        b = rnd8();
        if (b == sb.sync_val) b = b ^ 8'h01;
        send_req(CMD_RX, b, rnd10());
      end
      send_req(CMD_RX, sb.sync_val, rnd10());
    end
    pick = $urandom_range(0, 19);
    if (pick == 0)
      len = 32'd0;
    else if (pick == 1)
      len = $urandom() | 32'h0000_0800;
    else if (pick == 2)
      len = $urandom_range(30, 64);
    else
      len = $urandom_range(1, 16);
    send_length(len);
    // oversized frames never finish, so abandon them after a few bytes
    n_pay = (len > 64) ? $urandom_range(0, 8) : len;
    for (int i = 0; i < n_pay; i++) begin
      if ($urandom_range(0, 9) == 0) send_req(CMD_READ, rnd8(), rnd10());
      send_req(CMD_RX, rnd8(), rnd10());
    end
    repeat ($urandom_range(0, 2)) send_req(CMD_RX, rnd8(), rnd10());
    repeat ($urandom_range(1, 4)) begin
      if (len == 0 || len > 64 || $urandom_range(0, 3) == 0)
        send_req(CMD_READ, rnd8(), rnd10());
      else
        send_req(CMD_READ, rnd8(), 10'($urandom_range(0, len - 1)));
    end
    pick = $urandom_range(0, 9);
    if (pick < 5)
      send_req(CMD_RELEASE, rnd8(), rnd10());
    else if (pick < 8)
      send_req(CMD_RESTART, rnd8(), rnd10());
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 4)) send_req(cmd_t'($urandom_range(0, 3)), rnd8(), rnd10());
  endtask

  task automatic run_random(int target);
    while (requests_effective < target) begin
      idle_on  = ($urandom_range(0, 9) < 7);
      stall_on = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 4) == 0)
        run_noise();
      else
        run_frame();
      if ($urandom_range(0, 29) == 0) drain();
    end
  endtask

  initial begin
    sb = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_SYNC_BYTE;
    cfg_wdata        = 8'd0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_RX;
    in_ch.rx_byte    = 8'd0;
    in_ch.read_index = 10'd0;
    out_ch.ready     = 1'b1;
    idle_on          = 1'b0;
    stall_on         = 1'b0;
    stall_left       = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: phases, partial length, release and restart, reads
    send_req(CMD_RX, 8'h55, 10'd0);
    send_req(CMD_READ, 8'h00, 10'd0);
    send_req(CMD_RESTART, 8'h00, 10'd0);
    send_req(CMD_RX, SYNC_BYTE_RST, 10'h3ff);
    send_req(CMD_RX, 8'hff, 10'd0);
    send_req(CMD_RELEASE, 8'h00, 10'd0);
    send_length(32'd3);
    send_req(CMD_READ, 8'h00, 10'd0);
    send_req(CMD_RX, 8'hff, 10'd0);
    send_req(CMD_RX, 8'h00, 10'd0);
    send_req(CMD_RX, 8'ha5, 10'd0);
    send_req(CMD_RX, 8'h12, 10'd0);
    send_req(CMD_READ, 8'h00, 10'd0);
    send_req(CMD_READ, 8'h00, 10'd2);
    send_req(CMD_READ, 8'h00, 10'd3);
    send_req(CMD_READ, 8'h00, 10'h3ff);
    send_req(CMD_RELEASE, 8'h00, 10'd0);
    // zero length completes on the last prefix byte
    send_length(32'd0);
    send_req(CMD_READ, 8'h00, 10'd0);
    send_req(CMD_RESTART, 8'h00, 10'd0);

    // full buffer, then overflow, with extreme register values
    set_config(8'h00, 8'hff);
    idle_on  = 1'b1;
    stall_on = 1'b1;
    send_req(CMD_RX, 8'h00, 10'd0);
    send_length(BUF_DEPTH);
    for (int i = 0; i < BUF_DEPTH; i++) send_req(CMD_RX, rnd8(), rnd10());
    send_req(CMD_READ, 8'h00, 10'd0);
    send_req(CMD_READ, 8'h00, 10'h3ff);
    send_req(CMD_READ, 8'h00, 10'h1ff);
    send_req(CMD_READ, 8'h00, 10'h200);
    repeat (4) send_req(CMD_READ, rnd8(), rnd10());
    send_req(CMD_RELEASE, 8'h00, 10'd0);
    send_length(32'hffff_ffff);
    for (int i = 0; i <= BUF_DEPTH + 1; i++) send_req(CMD_RX, rnd8(), rnd10());
    send_req(CMD_READ, 8'h00, 10'd0);
    send_req(CMD_RESTART, 8'h00, 10'd0);

    // random frames under several register settings
    set_config(8'hff, 8'h00);
    run_random(requests_effective + 150);
    set_config(rnd8(), rnd8());
    run_random(requests_effective + 150);
    set_config(SYNC_BYTE_RST, ECHO_BYTE_RST);
    run_random(requests_effective + 140);
    // closing stretch runs at full rate on both sides
    idle_on  = 1'b0;
    stall_on = 1'b0;
    for (int i = 0; i < 8; i++) run_frame();

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    $display("covered %0d requests (%0d acted on), %0d frames completed, %0d reads served",
             requests_sent, requests_effective, sb.frames_done, sb.reads_served);
    $display("overflow events %0d, results checked %0d, mismatches %0d",
             sb.overflow_events, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule

// File: sim.f
src/lpfr_pkg.sv
src/lpfr_if.sv
src/lpfr_ram.sv
src/lpfr_front.sv
src/lpfr_queue.sv
src/lpfr_back.sv
src/length_prefixed_frame_receiver.sv
dv/tb.sv
